@@ sv/bis_pkg.sv @@
// ============================================================================
// bis_pkg: shared types and constants of the bilinear sample/splat block
// Widths, opcodes, queue entry and back-end state encodings.
// ============================================================================
package bis_pkg;

  localparam int MaxWidth  = 64;
  localparam int MaxHeight = 64;
  localparam int FracBits  = 8;

  localparam int XW    = $clog2(MaxWidth);
  localparam int YW    = $clog2(MaxHeight);
  localparam int Depth = MaxWidth * MaxHeight;
  localparam int AW    = $clog2(Depth);
  localparam int PixW  = 24;
  localparam int CrdW  = 17;
  localparam int DimW  = 7;
  localparam int WtW   = 2 * FracBits + 1;
  localparam int WsW   = WtW + 2;
  localparam int TotW  = PixW + WtW + 2;

  localparam logic signed [PixW-1:0] PixMax = {1'b0, {(PixW-1){1'b1}}};
  localparam logic signed [PixW-1:0] PixMin = {1'b1, {(PixW-1){1'b0}}};

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_SPLAT = 2'd1,
    OP_MASK  = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_WIDTH   = 2'd0,
    REG_HEIGHT  = 2'd1,
    REG_MISSING = 2'd2
  } reg_idx_t;

  // Classified request handed from front to back.
  typedef struct packed {
    op_t                       op;
    logic                      oob;
    logic [3:0]                inr;
    logic [3:0][AW-1:0]        addr;
    logic [3:0][WtW-1:0]       wt;
    logic signed [PixW-1:0]    val;
  } req_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_RD,
    BK_ACC,
    BK_DIV,
    BK_OUT,
    BK_CLR
  } bk_state_t;

endpackage

@@ sv/bis_front.sv @@
// ============================================================================
// bis_front: request classifier
// Registers an accepted request, splits coordinates into base pixel and
// fraction, computes the four bilinear weights and store addresses.
// ============================================================================
module bis_front
  import bis_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             in_opcode,
  input  logic signed [CrdW-1:0] in_coord_x,
  input  logic signed [CrdW-1:0] in_coord_y,
  input  logic signed [PixW-1:0] in_pixel_in,
  input  logic [DimW-1:0]        width_i,
  input  logic [DimW-1:0]        height_i,
  output logic                   q_valid,
  input  logic                   q_full,
  output req_t                   q_data
);

  logic                   s1_v_r;
  logic [1:0]             s1_op_r;
  logic signed [CrdW-1:0] s1_x_r, s1_y_r;
  logic signed [PixW-1:0] s1_val_r;
  logic                   take;

  assign in_stall = s1_v_r && q_full;
  assign take     = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (!in_stall) begin
      s1_v_r <= in_valid;
    end
    if (take) begin
      s1_op_r  <= in_opcode;
      s1_x_r   <= in_coord_x;
      s1_y_r   <= in_coord_y;
      s1_val_r <= in_pixel_in;
    end
  end

  // effective dimensions
  logic [DimW-1:0] ew, eh;
  assign ew = (width_i  > DimW'(MaxWidth))  ? DimW'(MaxWidth)  : width_i;
  assign eh = (height_i > DimW'(MaxHeight)) ? DimW'(MaxHeight) : height_i;

  // base pixel and fraction; write uses the plain floor
  localparam logic signed [CrdW:0] Half = (CrdW+1)'(1 << (FracBits - 1));
  logic signed [CrdW:0] cx, cy;
  logic signed [CrdW-FracBits:0] bx, by;
  logic [FracBits-1:0] fx, fy;
  logic [FracBits:0]   gx, gy;
  always_comb begin
    if (s1_op_r == OP_WRITE) begin
      cx = {s1_x_r[CrdW-1], s1_x_r};
      cy = {s1_y_r[CrdW-1], s1_y_r};
    end else begin
      cx = {s1_x_r[CrdW-1], s1_x_r} - Half;
      cy = {s1_y_r[CrdW-1], s1_y_r} - Half;
    end
    bx = cx[CrdW:FracBits];
    by = cy[CrdW:FracBits];
    fx = cx[FracBits-1:0];
    fy = cy[FracBits-1:0];
    gx = (FracBits+1)'(1 << FracBits) - {1'b0, fx};
    gy = (FracBits+1)'(1 << FracBits) - {1'b0, fy};
  end

  // per-neighbour range, address and weight
  localparam int PW = CrdW - FracBits + 2;
  req_t rq;
  always_comb begin
    logic signed [PW-1:0] px, py;
    rq     = '0;
    rq.op  = op_t'(s1_op_r);
    rq.val = s1_val_r;
    rq.oob = s1_x_r < 0 || s1_y_r < 0
          || s1_x_r > $signed({1'b0, ew, {FracBits{1'b0}}})
          || s1_y_r > $signed({1'b0, eh, {FracBits{1'b0}}});
    for (int k = 0; k < 4; k++) begin
      px = PW'(bx) + PW'(k % 2);
      py = PW'(by) + PW'(k / 2);
      rq.inr[k] = px >= 0 && py >= 0 && px < $signed(PW'(ew)) && py < $signed(PW'(eh))
               && (s1_op_r != OP_WRITE || k == 0);
      rq.addr[k] = AW'(py[YW-1:0] * ew + AW'(px[XW-1:0]));
    end
    rq.wt[0] = WtW'(gx * gy);
    rq.wt[1] = WtW'({1'b0, fx} * gy);
    rq.wt[2] = WtW'(gx * {1'b0, fy});
    rq.wt[3] = WtW'({1'b0, fx} * {1'b0, fy});
  end

  assign q_valid = s1_v_r;
  assign q_data  = rq;

endmodule

@@ sv/bis_queue.sv @@
// ============================================================================
// bis_queue: two-entry request queue
// Decouples the classifier from the store sequencer.
// ============================================================================
module bis_queue
  import bis_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push_i,
  input  req_t push_data_i,
  output logic full_o,
  output logic valid_o,
  input  logic pop_i,
  output req_t data_o
);

  req_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full_o  = cnt_r == 2'd2;
  assign valid_o = cnt_r != 2'd0;
  assign data_o  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push_i) wp_r <= ~wp_r;
      if (pop_i)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push_i) - 2'(pop_i);
    end
    if (push_i) mem_r[wp_r] <= push_data_i;
  end

`ifndef SYNTHESIS
  a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
    full_o |-> !push_i || pop_i) else $error("queue overflow");
  a_no_under: assert property (@(posedge clk) disable iff (!rst_n)
    pop_i |-> valid_o) else $error("queue underflow");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count");
`endif

endmodule

@@ sv/bis_back.sv @@
// ============================================================================
// bis_back: store sequencer
// Clears the image store after reset, walks the four neighbours of each splat,
// mask or in-range read via a read-modify-write port, divides reads serially.
// ============================================================================
module bis_back
  import bis_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  req_t                   q_data,
  output logic                   q_pop,
  input  logic signed [PixW-1:0] missing_i,
  output logic                   busy_o,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [PixW-1:0] out_pixel_out
);

  logic signed [PixW-1:0] mem [Depth];

  bk_state_t              st_r, st_nxt;
  req_t                   rq_r;
  logic [1:0]             k_r;
  logic [AW:0]            clr_r;
  logic signed [PixW-1:0] rd_r;
  logic [WsW-1:0]         ws_r;
  logic signed [TotW-1:0] tot_r;
  logic [TotW-1:0]        quo_r, rem_r;
  logic [5:0]             dc_r;
  logic                   neg_r;
  logic                   ov_r;
  logic signed [PixW-1:0] ob_r;

  // splat product, truncated toward zero
  logic signed [PixW+WtW:0] prod;
  logic signed [PixW+WtW:0] addv;
  logic signed [PixW+1:0]   sum;
  logic signed [PixW-1:0]   wr_val;
  logic                     use_k;
  always_comb begin
    prod = $signed(rq_r.val) * $signed({1'b0, rq_r.wt[k_r]});
    if (prod < 0) addv = -((-prod) >>> (2 * FracBits));
    else          addv = prod >>> (2 * FracBits);
    sum = (PixW+2)'(rd_r) + (PixW+2)'(addv);
    if (sum > (PixW+2)'(PixMax))      wr_val = PixMax;
    else if (sum < (PixW+2)'(PixMin)) wr_val = PixMin;
    else                              wr_val = sum[PixW-1:0];
    use_k = rq_r.inr[k_r] && rd_r != missing_i;
  end

  logic [TotW:0] trial;
  assign trial = {rem_r[TotW-2:0], quo_r[TotW-1]} - {1'b0, TotW'(ws_r)};

  assign busy_o   = st_r != BK_IDLE;
  assign out_valid = ov_r;
  assign out_pixel_out = ob_r;

  // next state
  always_comb begin
    st_nxt = st_r;
    q_pop  = 1'b0;
    unique case (st_r)
      BK_CLR:  if (clr_r == (AW+1)'(Depth - 1)) st_nxt = BK_IDLE;
      BK_IDLE: if (q_valid && !ov_r) begin
        q_pop = 1'b1;
        if (q_data.op == OP_READ && q_data.oob) st_nxt = BK_OUT;
        else if (q_data.op == OP_WRITE)         st_nxt = BK_IDLE;
        else                                    st_nxt = BK_RD;
      end
      BK_RD:   st_nxt = BK_ACC;
      BK_ACC:  if (k_r == 2'd3) st_nxt = (rq_r.op == OP_READ) ? BK_DIV : BK_IDLE;
               else st_nxt = BK_RD;
      BK_DIV:  if (ws_r == '0 || dc_r == 6'(TotW)) st_nxt = BK_OUT;
      BK_OUT:  st_nxt = BK_IDLE;
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= BK_CLR;
      clr_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == BK_CLR) clr_r <= clr_r + 1'b1;
      if (st_r == BK_OUT)          ov_r <= 1'b1;
      else if (ov_r && !out_stall) ov_r <= 1'b0;
    end
    // memory port and datapath
    unique case (st_r)
      BK_CLR: mem[clr_r[AW-1:0]] <= '0;
      BK_IDLE: if (q_pop) begin
        rq_r  <= q_data;
        k_r   <= 2'd0;
        ws_r  <= '0;
        tot_r <= '0;
        dc_r  <= '0;
        quo_r <= '0;
        rem_r <= '0;
        if (q_data.op == OP_WRITE && q_data.inr[0]) mem[q_data.addr[0]] <= q_data.val;
      end
      BK_RD: rd_r <= mem[rq_r.addr[k_r]];
      BK_ACC: begin
        k_r <= k_r + 2'd1;
        if (rq_r.inr[k_r] && rq_r.op == OP_MASK)  mem[rq_r.addr[k_r]] <= missing_i;
        if (rq_r.inr[k_r] && rq_r.op == OP_SPLAT) mem[rq_r.addr[k_r]] <= wr_val;
        if (rq_r.op == OP_READ && use_k) begin
          ws_r  <= ws_r + WsW'(rq_r.wt[k_r]);
          tot_r <= tot_r + TotW'(rd_r * $signed({1'b0, rq_r.wt[k_r]}));
        end
        if (k_r == 2'd3) begin
          neg_r <= 1'b0;
        end
      end
      BK_DIV: begin
        if (dc_r == '0) begin
          neg_r <= tot_r < 0;
          quo_r <= (tot_r < 0) ? TotW'(-tot_r) : TotW'(tot_r);
          rem_r <= '0;
          dc_r  <= 6'd1;
        end else begin
          dc_r <= dc_r + 6'd1;
          if (!trial[TotW]) begin
            rem_r <= trial[TotW-1:0];
            quo_r <= {quo_r[TotW-2:0], 1'b1};
          end else begin
            rem_r <= {rem_r[TotW-2:0], quo_r[TotW-1]};
            quo_r <= {quo_r[TotW-2:0], 1'b0};
          end
        end
      end
      BK_OUT: begin
        if (rq_r.op == OP_READ && !rq_r.oob && ws_r != '0)
          ob_r <= neg_r ? PixW'(-quo_r) : PixW'(quo_r);
        else
          ob_r <= missing_i;
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_clr: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == BK_CLR |-> !q_pop) else $error("pop during clear");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && out_stall |=> ov_r && $stable(ob_r)) else $error("result lost");
  a_ws: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == BK_DIV |-> ws_r <= WsW'(1 << (2 * FracBits))) else $error("weight sum too big");
`endif

endmodule

@@ sv/bilinear_image_sample_splat.sv @@
// ============================================================================
// bilinear_image_sample_splat: bilinear sample/splat image store
// Top level: config registers, classifier, queue and store sequencer.
// ============================================================================
// After reset the 4096-entry store is cleared before the first item is
// carried out; up to three items wait in the front stage and queue
// meanwhile. A front stage registers and classifies each item; a
// two-entry queue feeds a sequencer with one store port. A write is
// stored as it is taken; splat and mask take the item, then read and
// update each neighbour in turn; an interpolated read reads and weighs
// each neighbour, then runs a bit-serial divide (cut short when no
// neighbour is valid) and an output step. A waiting result holds off the
// next item. The single store port and the serial divider set the rate.
module bilinear_image_sample_splat
  import bis_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             in_opcode,
  input  logic signed [CrdW-1:0] in_coord_x,
  input  logic signed [CrdW-1:0] in_coord_y,
  input  logic signed [PixW-1:0] in_pixel_in,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [PixW-1:0] out_pixel_out,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [PixW-1:0]        cfg_data
);

  logic [DimW-1:0]        width_r, height_r;
  logic signed [PixW-1:0] missing_r;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= DimW'(64);
      height_r  <= DimW'(64);
      missing_r <= -PixW'(9999);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WIDTH:   width_r   <= cfg_data[DimW-1:0];
        REG_HEIGHT:  height_r  <= cfg_data[DimW-1:0];
        REG_MISSING: missing_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic qv, qf, qpop, qout_v, busy;
  req_t qd, qo;

  bis_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_opcode, .in_coord_x, .in_coord_y,
    .in_pixel_in, .width_i(width_r), .height_i(height_r),
    .q_valid(qv), .q_full(qf), .q_data(qd)
  );

  bis_queue u_queue (
    .clk, .rst_n, .push_i(qv && !qf), .push_data_i(qd), .full_o(qf),
    .valid_o(qout_v), .pop_i(qpop), .data_o(qo)
  );

  bis_back u_back (
    .clk, .rst_n, .q_valid(qout_v), .q_data(qo), .q_pop(qpop),
    .missing_i(missing_r), .busy_o(busy), .out_valid, .out_stall, .out_pixel_out
  );

`ifndef SYNTHESIS
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    qpop |-> !busy) else $error("pop while busy");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> qf) else $error("stall without full queue");
  a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_index == REG_WIDTH |=> width_r == $past(cfg_data[DimW-1:0]))
    else $error("width write");
`endif

endmodule
